### rtl/core/dcu_pkg.sv
// Package for the converter channel update scheduler.
// Request/result payload types, controller commands and fixed codes.
// No dependencies.
package dcu_pkg;

  typedef struct packed {
    logic              cmd;
    logic signed [7:0] channel;
    logic [15:0]       value;
    logic              bus_free;
  } req_t;

  typedef struct packed {
    logic [7:0]  frame_cmd;
    logic [15:0] frame_data;
    logic [2:0]  served_slot;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_UPDATE = 1'b1;

  localparam logic [1:0] CFG_SET_ONE_BASE = 2'd0;
  localparam logic [1:0] CFG_SET_ALL      = 2'd1;
  localparam logic [1:0] CFG_REFRESH_ALL  = 2'd2;

  localparam logic [7:0] SET_ONE_BASE_RST = 8'd16;
  localparam logic [7:0] SET_ALL_RST      = 8'd52;
  localparam logic [7:0] REFRESH_ALL_RST  = 8'd48;

  localparam logic [7:0] CHAN_SET_ALL = 8'hFF;
  localparam logic [2:0] BCAST_SLOT   = 3'd4;

endpackage

### rtl/core/dac_channel_update_scheduler_unit.sv
// Converter channel update scheduler, top level.
// The request is registered on acceptance; strobe and frame are registered together in the execute state.
// No new request is accepted while busy, that is, during the controller's single execute state.
// Write requests, bus-busy updates and updates with nothing dirty produce no strobe.
// Reset (async, active low) clears all slots and the round-robin pointer, restores config.
// The receiver cannot stall; each result is shown for exactly one cycle.
module dac_channel_update_scheduler_unit
  import dcu_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output res_t       res_o,
  output logic       result_valid_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  ctrl_cmd_t ctrl;

  dcu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  dcu_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .res_o          (res_o),
    .result_valid_o (result_valid_o)
  );

  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result strobe without a preceding execute cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (res_o.served_slot < 3'(NUM_CHANNELS)) ||
                       (res_o.served_slot == BCAST_SLOT))
    else $error("served slot out of range");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

### rtl/core/dcu_ctrl.sv
// Controller FSM for the channel update scheduler.
// Sequences request capture and execution; uses dcu_pkg.
module dcu_ctrl
  import dcu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy        = busy_q;
  assign ctrl_o.load = start && (state_q == ST_IDLE);
  assign ctrl_o.exec = (state_q == ST_EXEC);

endmodule

### rtl/core/dcu_datapath.sv
// Datapath for the channel update scheduler: slots, config, arbiter, result.
// Driven by dcu_ctrl commands; uses dcu_pkg.
module dcu_datapath
  import dcu_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  ctrl_i,
  input  req_t       req_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output res_t       res_o,
  output logic       result_valid_o
);

  localparam int LW = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IW = LW + 1;

  req_t        req_q;
  logic [7:0]  base_q, set_all_q, refresh_q;
  logic        dirty_q [NUM_CHANNELS];
  logic [7:0]  command_q [NUM_CHANNELS];
  logic [15:0] value_q [NUM_CHANNELS];
  logic        bc_dirty_q;
  logic [7:0]  bc_command_q;
  logic [15:0] bc_value_q;
  logic [LW-1:0] last_q;
  res_t        res_q;
  logic        valid_q;

  logic          hit;
  logic [LW-1:0] win;
  logic [IW-1:0] sum;
  logic          chan_ok;
  logic [LW-1:0] chan_idx;

  // round-robin search starting after the last served channel
  always_comb begin
    hit = 1'b0;
    win = '0;
    sum = '0;
    for (int k = NUM_CHANNELS; k >= 1; k--) begin
      sum = IW'(last_q) + IW'(k);
      if (sum >= IW'(NUM_CHANNELS)) sum = sum - IW'(NUM_CHANNELS);
      if (dirty_q[sum[LW-1:0]]) begin
        hit = 1'b1;
        win = sum[LW-1:0];
      end
    end
  end

  assign chan_ok  = !req_q.channel[7] && (req_q.channel < 8'(NUM_CHANNELS));
  assign chan_idx = req_q.channel[LW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= SET_ONE_BASE_RST;
      set_all_q <= SET_ALL_RST;
      refresh_q <= REFRESH_ALL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_ONE_BASE: base_q    <= cfg_data_i;
        CFG_SET_ALL:      set_all_q <= cfg_data_i;
        CFG_REFRESH_ALL:  refresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        dirty_q[i]   <= 1'b0;
        command_q[i] <= '0;
        value_q[i]   <= '0;
      end
      bc_dirty_q   <= 1'b0;
      bc_command_q <= '0;
      bc_value_q   <= '0;
      last_q       <= '0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (ctrl_i.exec) begin
        if (req_q.cmd == CMD_WRITE) begin
          if (req_q.channel[7]) begin
            bc_dirty_q   <= 1'b1;
            bc_command_q <= (req_q.channel == CHAN_SET_ALL) ? set_all_q : refresh_q;
            bc_value_q   <= req_q.value;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              dirty_q[i] <= 1'b0;
              value_q[i] <= req_q.value;
            end
          end else if (chan_ok && (value_q[chan_idx] != req_q.value)) begin
            dirty_q[chan_idx]   <= 1'b1;
            command_q[chan_idx] <= base_q | {req_q.channel[6:0], 1'b0};
            value_q[chan_idx]   <= req_q.value;
          end
        end else if (req_q.bus_free) begin
          if (bc_dirty_q) begin
            bc_dirty_q <= 1'b0;
            valid_q    <= 1'b1;
          end else if (hit) begin
            dirty_q[win] <= 1'b0;
            last_q       <= win;
            valid_q      <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (bc_dirty_q) begin
        res_q.frame_cmd   <= bc_command_q;
        res_q.frame_data  <= bc_value_q;
        res_q.served_slot <= BCAST_SLOT;
      end else begin
        res_q.frame_cmd   <= command_q[win];
        res_q.frame_data  <= value_q[win];
        res_q.served_slot <= 3'(win);
      end
    end
  end

  assign res_o          = res_q;
  assign result_valid_o = valid_q;

endmodule

### test/tb_dac_channel_update_scheduler_unit.sv
// Testbench for the converter channel update scheduler: directed and random requests.
// A scoreboard class predicts frames and slot state; depends on dcu_pkg and the top level.
`timescale 1ns / 1ps

module tb_dac_channel_update_scheduler_unit;
  import dcu_pkg::*;

  localparam int NCH         = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int RAND_PHASE  = 160;

  class frame_tracker #(int CHANS = 4);
    logic        dirty_mark [5];
    logic [7:0]  cmd_byte   [5];
    logic [15:0] sample     [5];
    logic [1:0]  rr_ptr;
    logic [7:0]  base_one;
    logic [7:0]  all_code;
    logic [7:0]  refresh_code;
    res_t        frame_q [$];
    int          errors;

    function new();
      for (int i = 0; i < 5; i++) begin
        dirty_mark[i] = 1'b0;
        cmd_byte[i]   = '0;
        sample[i]     = '0;
      end
      rr_ptr       = '0;
      base_one     = SET_ONE_BASE_RST;
      all_code     = SET_ALL_RST;
      refresh_code = REFRESH_ALL_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_SET_ONE_BASE: base_one = data;
        CFG_SET_ALL:      all_code = data;
        CFG_REFRESH_ALL:  refresh_code = data;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return frame_q.size();
    endfunction

    function void take_request(req_t r);
      logic [7:0] cb;
      int         pick;
      int         c;
      res_t       f;
      cb   = r.channel;
      pick = -1;
      if (r.cmd == CMD_WRITE) begin
        if (cb[7]) begin
          dirty_mark[BCAST_SLOT] = 1'b1;
          cmd_byte[BCAST_SLOT]   = (cb == CHAN_SET_ALL) ? all_code : refresh_code;
          sample[BCAST_SLOT]     = r.value;
          for (int i = 0; i < CHANS; i++) begin
            dirty_mark[i] = 1'b0;
            sample[i]     = r.value;
          end
        end else if (int'(cb) < CHANS && sample[cb] != r.value) begin
          dirty_mark[cb] = 1'b1;
          cmd_byte[cb]   = base_one | 8'(cb << 1);
          sample[cb]     = r.value;
        end
        return;
      end
      if (!r.bus_free) return;
      if (dirty_mark[BCAST_SLOT]) begin
        pick = BCAST_SLOT;
      end else begin
        for (int i = 1; i <= CHANS; i++) begin
          c = (int'(rr_ptr) + i) % CHANS;
          if (pick < 0 && dirty_mark[c]) pick = c;
        end
        if (pick < 0) return;
        rr_ptr = 2'(pick);
      end
      f.frame_cmd   = cmd_byte[pick];
      f.frame_data  = sample[pick];
      f.served_slot = 3'(pick);
      dirty_mark[pick] = 1'b0;
      frame_q.push_back(f);
    endfunction

    function void match_frame(res_t got);
      res_t want;
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected frame cmd %0h data %0h slot %0d", $time,
                 got.frame_cmd, got.frame_data, got.served_slot);
        errors++;
        return;
      end
      want = frame_q.pop_front();
      if (got.frame_cmd !== want.frame_cmd) begin
        $display("%0t: frame_cmd expected %0h actual %0h", $time, want.frame_cmd,
                 got.frame_cmd);
        errors++;
      end
      if (got.frame_data !== want.frame_data) begin
        $display("%0t: frame_data expected %0h actual %0h", $time, want.frame_data,
                 got.frame_data);
        errors++;
      end
      if (got.served_slot !== want.served_slot) begin
        $display("%0t: served_slot expected %0d actual %0d", $time, want.served_slot,
                 got.served_slot);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  logic       busy;
  req_t       req_i      = '0;
  res_t       res_o;
  logic       result_valid_o;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = CFG_SET_ONE_BASE;
  logic [7:0] cfg_data_i = '0;

  frame_tracker #(NCH) board;
  int idle_pct = 31;
  int quiet_cycles = 0;

  dac_channel_update_scheduler_unit #(.NUM_CHANNELS(NCH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .res_o         (res_o),
    .result_valid_o(result_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.match_frame(res_o);
      if (start && !busy) board.take_request(req_i);
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("dac_channel_update_scheduler_unit test failed");
        $finish;
      end
    end
  end

  task automatic send_req(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_fields(input logic cmd, input logic [7:0] ch, input logic [15:0] val,
                             input logic bf);
    req_t r;
    r.cmd      = cmd;
    r.channel  = ch;
    r.value    = val;
    r.bus_free = bf;
    send_req(r);
  endtask

  // stop issuing, let every predicted frame arrive, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] one, input logic [7:0] all,
                          input logic [7:0] refresh);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SET_ONE_BASE;
    cfg_data_i <= one;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SET_ALL;
    cfg_data_i <= all;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_REFRESH_ALL;
    cfg_data_i <= refresh;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    r.cmd = ($urandom_range(0, 1) == 1) ? CMD_UPDATE : CMD_WRITE;
    sel = $urandom_range(0, 99);
    if (sel < 70)      r.channel = 8'($urandom_range(0, NCH - 1));
    else if (sel < 78) r.channel = CHAN_SET_ALL;
    else if (sel < 86) r.channel = 8'($urandom_range(128, 254));
    else if (sel < 93) r.channel = 8'($urandom_range(NCH, 127));
    else               r.channel = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       r.value = 16'h0000;
      1:       r.value = 16'hFFFF;
      2, 3:    r.value = 16'($urandom_range(0, 3));
      default: r.value = 16'($urandom);
    endcase
    r.bus_free = ($urandom_range(0, 99) < 80);
    return r;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_req(rand_req());
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing dirty, bus busy, unchanged value
    send_fields(CMD_UPDATE, 8'd0, 16'h0000, 1'b1);
    send_fields(CMD_UPDATE, 8'd0, 16'h0000, 1'b0);
    send_fields(CMD_WRITE, 8'd0, 16'h0000, 1'b1);
    send_fields(CMD_UPDATE, 8'd0, 16'h0000, 1'b1);
    // every channel, out-of-range channels, round-robin order
    send_fields(CMD_WRITE, 8'd0, 16'hFFFF, 1'b0);
    send_fields(CMD_WRITE, 8'd1, 16'h0001, 1'b1);
    send_fields(CMD_WRITE, 8'd2, 16'h8000, 1'b0);
    send_fields(CMD_WRITE, 8'd3, 16'hAAAA, 1'b1);
    send_fields(CMD_WRITE, 8'd4, 16'h5555, 1'b1);
    send_fields(CMD_WRITE, 8'd127, 16'h1234, 1'b0);
    send_fields(CMD_UPDATE, 8'hFF, 16'hFFFF, 1'b0);
    repeat (5) send_fields(CMD_UPDATE, 8'($urandom), 16'($urandom), 1'b1);
    // broadcast write, then a single write that matches the copied value
    send_fields(CMD_WRITE, 8'd2, 16'h0F0F, 1'b1);
    send_fields(CMD_WRITE, CHAN_SET_ALL, 16'h1234, 1'b0);
    send_fields(CMD_WRITE, 8'd0, 16'h1234, 1'b1);
    send_fields(CMD_WRITE, 8'h80, 16'h5555, 1'b1);
    send_fields(CMD_WRITE, 8'd1, 16'h0000, 1'b0);
    send_fields(CMD_WRITE, 8'hFE, 16'hC3C3, 1'b1);
    repeat (3) send_fields(CMD_UPDATE, 8'h7F, 16'hFFFF, 1'b1);
    random_phase(RAND_PHASE);
    drain();

    set_regs(8'h00, 8'h00, 8'h00);
    random_phase(RAND_PHASE);
    drain();

    idle_pct = 0;
    set_regs(8'hFF, 8'hFF, 8'hFF);
    random_phase(RAND_PHASE);
    drain();

    idle_pct = 31;
    set_regs(8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(RAND_PHASE);
    drain();

    set_regs(8'hA0, 8'h5A, 8'h3C);
    random_phase(RAND_PHASE);
    drain();

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("dac_channel_update_scheduler_unit test passed");
    end else begin
      $display("dac_channel_update_scheduler_unit test failed");
    end
    $finish;
  end

endmodule

### dac_channel_update_scheduler_unit.f
rtl/core/dcu_pkg.sv
rtl/core/dcu_ctrl.sv
rtl/core/dcu_datapath.sv
rtl/core/dac_channel_update_scheduler_unit.sv
test/tb_dac_channel_update_scheduler_unit.sv
